// ===== rtl/core/rcp_pkg.sv =====
// rcp_pkg: shared types, codes and character tables for the array command parser
// used by every module under rtl/core; depends on nothing
`timescale 1ns / 1ps

package rcp_pkg;

  // sizing
  localparam int LEN_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int CFG_INDEX_W      = 8;
  localparam int REG_W            = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ELEMENT_LENGTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ELEMENT_COUNT  = 8'd1;

  // command kinds
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_PING   = 2'd1;
  localparam logic [1:0] KIND_SELECT = 2'd2;
  localparam logic [1:0] KIND_INLINE = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DIGIT = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;

  // characters
  localparam logic [7:0] ASCII_STAR = 8'h2a;
  localparam logic [7:0] ASCII_CR   = 8'h0d;
  localparam logic [7:0] ASCII_LF   = 8'h0a;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  // command words: bit 0 PING, 1 ping, 2 SELECT, 3 select
  localparam logic [2:0] WORD_MAX_LEN = 3'd6;

  // classified input item
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_star;
  } item_t;

  // limit registers
  typedef struct packed {
    logic [REG_W-1:0] max_length;
    logic [REG_W-1:0] max_count;
  } cfg_t;

  function automatic logic [2:0] word_len(input logic [1:0] w);
    word_len = w[1] ? 3'd6 : 3'd4;
  endfunction

  // character of word w at offset off (offsets past the end give zero, or a space for the lower case words)
  function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] off);
    logic [7:0] c;
    c = 8'h00;
    case (w[1])
      1'b0: begin
        case (off)
          3'd0:    c = "P";
          3'd1:    c = "I";
          3'd2:    c = "N";
          3'd3:    c = "G";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (off)
          3'd0:    c = "S";
          3'd1:    c = "E";
          3'd2:    c = "L";
          3'd3:    c = "E";
          3'd4:    c = "C";
          3'd5:    c = "T";
          default: c = 8'h00;
        endcase
      end
    endcase
    // odd words are the lower case spellings
    word_char = w[0] ? (c | 8'h20) : c;
  endfunction

endpackage

// ===== rtl/core/rcp_front.sv =====
// rcp_front: input handshake and byte classification into queue items
// depends on rcp_pkg
`timescale 1ns / 1ps

module rcp_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          queue_full,
  output logic          push,
  output rcp_pkg::item_t push_item
);
  import rcp_pkg::*;

  // take an item whenever the queue has room
  assign in_stall = queue_full;
  assign push     = in_valid & ~queue_full;

  // classify the byte once so the back end only looks at flags
  always_comb begin
    logic [7:0] rel;
    rel                = data_byte - ASCII_ZERO;
    push_item.data     = data_byte;
    push_item.is_digit = (data_byte >= ASCII_ZERO) && (data_byte <= ASCII_NINE);
    push_item.digit    = rel[3:0];
    push_item.is_cr    = (data_byte == ASCII_CR);
    push_item.is_lf    = (data_byte == ASCII_LF);
    push_item.is_star  = (data_byte == ASCII_STAR);
  end

endmodule

// ===== rtl/core/rcp_queue.sv =====
// rcp_queue: short item queue between the classifier and the parser
// depends on rcp_pkg
`timescale 1ns / 1ps

module rcp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rcp_pkg::item_t head
);
  import rcp_pkg::*;

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // item storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rcp_back.sv =====
// rcp_back: command parser state machine and registered result stage
// depends on rcp_pkg; fed by rcp_queue, limits from the top level
`timescale 1ns / 1ps

module rcp_back #(
  parameter int LEN_BITS = rcp_pkg::LEN_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  rcp_pkg::cfg_t  cfg,
  input  logic           queue_empty,
  input  rcp_pkg::item_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     byte_echo,
  output logic           is_key_byte,
  output logic           command_done,
  output logic [1:0]     command_kind,
  output logic [31:0]    key_size,
  output logic [31:0]    command_bytes,
  output logic [1:0]     error_code
);
  import rcp_pkg::*;

  localparam int ACC_W = LEN_BITS + 4;
  localparam int CMP_W = (ACC_W > REG_W + 1) ? ACC_W : REG_W + 1;
  localparam int BL_W  = LEN_BITS + 1;

  // parser phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_COUNT     = 3'd1;
  localparam logic [2:0] PH_LF        = 3'd2;
  localparam logic [2:0] PH_MARK      = 3'd3;
  localparam logic [2:0] PH_DATA      = 3'd4;
  localparam logic [2:0] PH_INLINE    = 3'd5;
  localparam logic [2:0] PH_INLINE_CR = 3'd6;
  localparam logic [2:0] PH_RESYNC    = 3'd7;

  logic [2:0]          phase,            phase_next;
  logic [LEN_BITS-1:0] elements_left,    elements_left_next;
  logic [1:0]          element_ordinal,  element_ordinal_next;
  logic [BL_W-1:0]     bytes_left,       bytes_left_next;
  logic [LEN_BITS-1:0] acc,              acc_next;
  logic [1:0]          kind_so_far,      kind_so_far_next;
  logic [3:0]          match_flags,      match_flags_next;
  logic [LEN_BITS-1:0] saved_key_size,   saved_key_size_next;
  logic [REG_W-1:0]    byte_total,       byte_total_next;
  logic [2:0]          data_off,         data_off_next;

  logic                key, done, start_cmd, skip;
  logic [1:0]          err;
  logic [REG_W-1:0]    total_inc;
  logic [ACC_W-1:0]    acc_calc;
  logic [CMP_W-1:0]    acc_cmp, cap_cmp, lim_cmp;
  logic [CMP_W-1:0]    klen_ext;

  // advance when an item waits and the result register is free or drains
  assign pop = !queue_empty && (!out_valid || !out_stall);

  // accumulator step and limit compares
  always_comb begin
    acc_calc = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(head.digit);
    acc_cmp  = CMP_W'(acc_calc);
    cap_cmp  = CMP_W'({LEN_BITS{1'b1}});
    lim_cmp  = (element_ordinal == 2'd0) ? CMP_W'(cfg.max_count) : CMP_W'(cfg.max_length);
  end

  // next state of the parser
  always_comb begin
    phase_next            = phase;
    elements_left_next    = elements_left;
    element_ordinal_next  = element_ordinal;
    bytes_left_next       = bytes_left;
    acc_next              = acc;
    kind_so_far_next      = kind_so_far;
    match_flags_next      = match_flags;
    saved_key_size_next   = saved_key_size;
    byte_total_next       = byte_total;
    data_off_next         = data_off;
    key       = 1'b0;
    done      = 1'b0;
    start_cmd = 1'b0;
    skip      = 1'b0;
    err       = ERR_NONE;
    total_inc = (byte_total == '1) ? byte_total : byte_total + 1'b1;

    if (phase == PH_RESYNC && !head.is_star) begin
      // dropped while hunting for the next command start
      skip = 1'b1;
    end else begin
      byte_total_next = total_inc;
      case (phase)
        PH_IDLE, PH_RESYNC: begin
          start_cmd = 1'b1;
          if (head.is_star) begin
            phase_next = PH_COUNT;
          end else if (head.is_cr) begin
            phase_next = PH_INLINE_CR;
          end else begin
            phase_next = PH_INLINE;
          end
        end
        PH_COUNT: begin
          if (head.is_digit) begin
            acc_next        = acc_calc[LEN_BITS-1:0];
            bytes_left_next = BL_W'(1);
            if (acc_cmp > cap_cmp || acc_cmp > lim_cmp) begin
              err = ERR_OVER;
            end
          end else if (head.is_cr && bytes_left != '0) begin
            phase_next = PH_LF;
          end else begin
            err = ERR_DIGIT;
          end
        end
        PH_LF: begin
          if (!head.is_lf) begin
            err = ERR_DIGIT;
          end else if (element_ordinal == 2'd0) begin
            elements_left_next = acc;
            if (acc == '0) begin
              done = 1'b1;
            end else begin
              phase_next = PH_MARK;
            end
          end else begin
            if (element_ordinal == 2'd2) begin
              saved_key_size_next = acc;
            end
            bytes_left_next = BL_W'(acc) + BL_W'(2);
            data_off_next   = 3'd0;
            phase_next      = PH_DATA;
          end
        end
        PH_MARK: begin
          // element header mark is skipped unchecked
          if (element_ordinal != 2'd3) begin
            element_ordinal_next = element_ordinal + 2'd1;
          end
          acc_next        = '0;
          bytes_left_next = '0;
          phase_next      = PH_COUNT;
        end
        PH_DATA: begin
          if (bytes_left > BL_W'(2)) begin
            if (element_ordinal == 2'd1) begin
              for (int i = 0; i < 4; i++) begin
                if (data_off < word_len(2'(i)) && head.data != word_char(2'(i), data_off)) begin
                  match_flags_next[i] = 1'b0;
                end
              end
            end
            if (data_off != WORD_MAX_LEN) begin
              data_off_next = data_off + 3'd1;
            end
            if (element_ordinal == 2'd2) begin
              key = 1'b1;
            end
          end else if (bytes_left == BL_W'(2)) begin
            // first trailing byte: settle the kind from the first element
            if (element_ordinal == 2'd1) begin
              if ((match_flags[3:2] != 2'b00) && acc >= LEN_BITS'(6)) begin
                kind_so_far_next = KIND_SELECT;
              end else if ((match_flags[1:0] != 2'b00) && acc >= LEN_BITS'(4)) begin
                kind_so_far_next = KIND_PING;
              end else begin
                kind_so_far_next = KIND_OTHER;
              end
            end
          end else begin
            if (elements_left != '0) begin
              elements_left_next = elements_left - 1'b1;
            end
            if (elements_left_next == '0) begin
              done = 1'b1;
            end else begin
              phase_next = PH_MARK;
            end
          end
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - 1'b1;
          end
        end
        PH_INLINE: begin
          if (head.is_cr) begin
            phase_next = PH_INLINE_CR;
          end
        end
        default: begin
          if (head.is_lf) begin
            kind_so_far_next = KIND_INLINE;
            done             = 1'b1;
          end else if (!head.is_cr) begin
            phase_next = PH_INLINE;
          end
        end
      endcase

      if (err != ERR_NONE) begin
        phase_next      = PH_RESYNC;
        byte_total_next = '0;
        start_cmd       = 1'b1;
      end else if (done) begin
        phase_next      = PH_IDLE;
        byte_total_next = '0;
      end

      // fresh command context
      if (start_cmd) begin
        elements_left_next    = '0;
        element_ordinal_next  = '0;
        bytes_left_next       = '0;
        acc_next              = '0;
        kind_so_far_next      = KIND_OTHER;
        match_flags_next      = 4'hf;
        saved_key_size_next   = '0;
      end
    end

    klen_ext = CMP_W'(saved_key_size_next);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      elements_left    <= '0;
      element_ordinal  <= '0;
      bytes_left       <= '0;
      acc              <= '0;
      kind_so_far      <= KIND_OTHER;
      match_flags      <= 4'hf;
      saved_key_size   <= '0;
      byte_total       <= '0;
      data_off         <= '0;
    end else if (pop) begin
      phase            <= phase_next;
      elements_left    <= elements_left_next;
      element_ordinal  <= element_ordinal_next;
      bytes_left       <= bytes_left_next;
      acc              <= acc_next;
      kind_so_far      <= kind_so_far_next;
      match_flags      <= match_flags_next;
      saved_key_size   <= saved_key_size_next;
      byte_total       <= byte_total_next;
      data_off         <= data_off_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      byte_echo     <= head.data;
      is_key_byte   <= key;
      command_done  <= done;
      command_kind  <= done ? kind_so_far_next : KIND_OTHER;
      key_size      <= done ? klen_ext[31:0] : 32'd0;
      command_bytes <= skip ? 32'd0 : total_inc;
      error_code    <= err;
    end
  end

endmodule

// ===== rtl/core/resp_array_command_parser.sv =====
// resp_array_command_parser: top level of the array command stream parser
// depends on rcp_pkg, rcp_front, rcp_queue and rcp_back
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    data_byte
//   out      output     out_valid / out_stall  byte_echo, is_key_byte, command_done,
//                                              command_kind, key_size,
//                                              command_bytes, error_code
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one result per byte; each byte is queued, then parsed into the registered result stage
// sustained rate is one byte per cycle while out_stall is low
// a four-item queue parts the input from the parser, so input stalls only when
// the output has been stalled long enough to fill it
// rst is synchronous; it empties the queue, drops any held result and restores
// the limit registers to all ones; cfg is always ready
`timescale 1ns / 1ps

module resp_array_command_parser #(
  parameter int LEN_BITS = rcp_pkg::LEN_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         byte_echo,
  output logic                               is_key_byte,
  output logic                               command_done,
  output logic [1:0]                         command_kind,
  output logic [31:0]                        key_size,
  output logic [31:0]                        command_bytes,
  output logic [1:0]                         error_code,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rcp_pkg::REG_W-1:0]          cfg_data
);
  import rcp_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t head;
  logic  push, pop, queue_full, queue_empty;

  assign cfg_ready = 1'b1;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_length <= '1;
      cfg.max_count  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_ELEMENT_LENGTH: cfg.max_length <= cfg_data;
        REG_MAX_ELEMENT_COUNT:  cfg.max_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  rcp_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  rcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  rcp_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .queue_empty   (queue_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_echo     (byte_echo),
    .is_key_byte   (is_key_byte),
    .command_done  (command_done),
    .command_kind  (command_kind),
    .key_size      (key_size),
    .command_bytes (command_bytes),
    .error_code    (error_code)
  );

endmodule

// ===== rtl/core/rcp_checker.sv =====
// rcp_checker: port-level checks on the parser results, bound to the top level
// depends on rcp_pkg and resp_array_command_parser
`timescale 1ns / 1ps

module rcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  byte_echo,
  input logic        is_key_byte,
  input logic        command_done,
  input logic [1:0]  command_kind,
  input logic [31:0] key_size,
  input logic [31:0] command_bytes,
  input logic [1:0]  error_code
);
  import rcp_pkg::*;

  // kind and key length only carried on the closing item
  a_summary_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !command_done |-> command_kind == KIND_OTHER && key_size == 32'd0)
    else $error("command summary outside a closing item");

  // an error item neither closes a command nor is part of the key
  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> !command_done && !is_key_byte)
    else $error("error item flagged as done or key");

  // an inline command closes on its line feed
  a_inline_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_done && command_kind == KIND_INLINE |-> byte_echo == ASCII_LF)
    else $error("inline command closed on a byte other than line feed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_echo) && $stable(command_bytes))
    else $error("stalled result changed");

endmodule

bind resp_array_command_parser rcp_checker u_rcp_checker (.*);

// ===== verif/resp_array_command_parser_tb.sv =====
// resp_array_command_parser_tb: self-checking bench for the array command parser
// drives byte streams of commands, inline lines and noise; depends on rcp_pkg and the rtl
`timescale 1ns / 1ps

module resp_array_command_parser_tb;
  import rcp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;
  localparam logic [7:0] ASCII_DOLLAR = 8'h24;

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_LF, PH_MARK, PH_DATA, PH_INLINE, PH_INLINE_CR, PH_RESYNC
  } parse_phase_t;

  typedef struct packed {
    logic [7:0]  echo;
    logic        key;
    logic        done;
    logic [1:0]  kind;
    logic [31:0] klen;
    logic [31:0] total;
    logic [1:0]  err;
  } parse_result_t;

  // parser copy plus the queue of results still owed by the block
  class parse_board;
    parse_result_t awaited[$];
    logic [31:0]   max_len;
    logic [31:0]   max_cnt;
    parse_phase_t  ph;
    logic [63:0]   left;
    logic [63:0]   ordinal;
    logic [63:0]   remaining;
    logic [63:0]   number;
    logic [63:0]   saved_key;
    logic [1:0]    kind_acc;
    logic [3:0]    live;
    logic [31:0]   total_bytes;
    string         words[4];
    int unsigned   mismatches, checked, commands, pings, selects, inlines;
    int unsigned   key_bytes, digit_errs, over_errs;

    function new();
      words = '{"PING", "ping", "SELECT", "select"};
      max_len = '1;
      max_cnt = '1;
      ph = PH_IDLE;
      total_bytes = '0;
      restart();
    endfunction

    function void restart();
      left = '0;
      ordinal = '0;
      remaining = '0;
      number = '0;
      kind_acc = KIND_OTHER;
      live = 4'hf;
      saved_key = '0;
    endfunction

    function void set_limit(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
      if (idx == REG_MAX_ELEMENT_LENGTH) max_len = value;
      else if (idx == REG_MAX_ELEMENT_COUNT) max_cnt = value;
    endfunction

    // drop candidate words that disagree with this byte of the first element
    function void match_word(logic [63:0] off, logic [7:0] b);
      for (int i = 0; i < 4; i++) begin
        if (off < words[i].len() && b != words[i][int'(off)]) live[i] = 1'b0;
      end
    endfunction

    // work out the result of one accepted byte
    function void note_byte(logic [7:0] b);
      parse_result_t r;
      logic [63:0]   lim;
      logic          done_now;
      logic [1:0]    err;
      r = '0;
      r.echo = b;
      done_now = 1'b0;
      err = ERR_NONE;
      // dropped while hunting for the next star
      if (ph == PH_RESYNC && b != ASCII_STAR) begin
        awaited.push_back(r);
        return;
      end
      if (total_bytes != '1) total_bytes++;
      r.total = total_bytes;
      case (ph)
        PH_IDLE, PH_RESYNC: begin
          restart();
          if (b == ASCII_STAR) ph = PH_COUNT;
          else if (b == ASCII_CR) ph = PH_INLINE_CR;
          else ph = PH_INLINE;
        end
        PH_COUNT: begin
          if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
            lim = (ordinal == 0) ? {32'd0, max_cnt} : {32'd0, max_len};
            number = number * 10 + (b - ASCII_ZERO);
            remaining = 64'd1;
            if (number > 64'hffff_ffff || number > lim) err = ERR_OVER;
          end else if (b == ASCII_CR && remaining != 0) begin
            ph = PH_LF;
          end else begin
            err = ERR_DIGIT;
          end
        end
        PH_LF: begin
          if (b != ASCII_LF) begin
            err = ERR_DIGIT;
          end else if (ordinal == 0) begin
            left = number;
            if (left == 0) done_now = 1'b1;
            else ph = PH_MARK;
          end else begin
            if (ordinal == 2) saved_key = number;
            remaining = number + 2;
            ph = PH_DATA;
          end
        end
        PH_MARK: begin
          if (ordinal < 3) ordinal++;
          number = '0;
          remaining = '0;
          ph = PH_COUNT;
        end
        PH_DATA: begin
          if (remaining > 2) begin
            if (ordinal == 1) match_word(number - (remaining - 2), b);
            if (ordinal == 2) r.key = 1'b1;
          end else if (remaining == 2) begin
            if (ordinal == 1) begin
              if ((|live[3:2]) && number >= 6) kind_acc = KIND_SELECT;
              else if ((|live[1:0]) && number >= 4) kind_acc = KIND_PING;
              else kind_acc = KIND_OTHER;
            end
          end else begin
            if (left != 0) left--;
            if (left == 0) done_now = 1'b1;
            else ph = PH_MARK;
          end
          if (remaining != 0) remaining--;
        end
        PH_INLINE: begin
          if (b == ASCII_CR) ph = PH_INLINE_CR;
        end
        default: begin
          if (b == ASCII_LF) begin
            kind_acc = KIND_INLINE;
            done_now = 1'b1;
          end else if (b != ASCII_CR) begin
            ph = PH_INLINE;
          end
        end
      endcase
      if (err != ERR_NONE) begin
        r.err = err;
        ph = PH_RESYNC;
        total_bytes = '0;
        restart();
      end else if (done_now) begin
        r.done = 1'b1;
        r.kind = kind_acc;
        r.klen = saved_key[31:0];
        ph = PH_IDLE;
        total_bytes = '0;
      end
      awaited.push_back(r);
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 1'b1;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    endfunction

    // compare one result from the block with the oldest prediction
    function void check_byte(parse_result_t got);
      parse_result_t want;
      bit            ok;
      if (awaited.size() == 0) begin
        $display("%0t ns: result with nothing awaited, expected none, got byte %0h",
                 $time, got.echo);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      ok = field_ok("byte_echo", 32'(want.echo), 32'(got.echo));
      ok &= field_ok("is_key_byte", 32'(want.key), 32'(got.key));
      ok &= field_ok("command_done", 32'(want.done), 32'(got.done));
      ok &= field_ok("command_kind", 32'(want.kind), 32'(got.kind));
      ok &= field_ok("key_size", want.klen, got.klen);
      ok &= field_ok("command_bytes", want.total, got.total);
      ok &= field_ok("error_code", 32'(want.err), 32'(got.err));
      if (!ok) mismatches++;
      checked++;
      if (want.key) key_bytes++;
      if (want.err == ERR_DIGIT) digit_errs++;
      if (want.err == ERR_OVER) over_errs++;
      if (want.done) begin
        commands++;
        if (want.kind == KIND_PING) pings++;
        if (want.kind == KIND_SELECT) selects++;
        if (want.kind == KIND_INLINE) inlines++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             data_byte;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             byte_echo;
  logic                   is_key_byte;
  logic                   command_done;
  logic [1:0]             command_kind;
  logic [31:0]            key_size;
  logic [31:0]            command_bytes;
  logic [1:0]             error_code;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_data;

  parse_board  board;
  logic [7:0]  stream[$];
  bit          idle_on;
  int unsigned cycles = 0;
  string       first_words[12] = '{"PING", "ping", "SELECT", "select", "PINGER", "selected",
                                   "Ping", "SeLeCt", "PIN", "SELEC", "GET", "set"};

  resp_array_command_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .byte_echo(byte_echo),
    .is_key_byte(is_key_byte), .command_done(command_done), .command_kind(command_kind),
    .key_size(key_size), .command_bytes(command_bytes), .error_code(error_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 35);
  end

  // result checking
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid && !out_stall) begin
      board.check_byte(parse_result_t'({byte_echo, is_key_byte, command_done, command_kind,
                                        key_size, command_bytes, error_code}));
    end
  end

  // stream building
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
  endtask

  task automatic put_crlf();
    stream.push_back(ASCII_CR);
    stream.push_back(ASCII_LF);
  endtask

  task automatic put_count(input logic [7:0] mark, input int unsigned n);
    stream.push_back(mark);
    if ($urandom_range(0, 9) == 0) stream.push_back(ASCII_ZERO);
    put_text($sformatf("%0d", n));
    put_crlf();
  endtask

  // random byte other than a star or a carriage return
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == ASCII_STAR || b == ASCII_CR) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // well-formed array command with random content; fit keeps it within the limits
  task automatic add_array_command(input bit fit);
    int unsigned n;
    int unsigned len;
    int          e;
    string       word;
    logic [7:0]  body[$];
    logic [7:0]  mark;
    n = $urandom_range(0, 4);
    if (fit && n > board.max_cnt) n = board.max_cnt;
    put_count(ASCII_STAR, n);
    for (e = 0; e < n; e++) begin
      body.delete();
      if (e == 0 && $urandom_range(0, 9) < 8) begin
        word = first_words[$urandom_range(0, 11)];
        for (int i = 0; i < word.len(); i++) body.push_back(word[i]);
      end else begin
        len = $urandom_range(0, 10);
        repeat (len) body.push_back(8'($urandom_range(0, 255)));
      end
      if (fit) while (body.size() > board.max_len) void'(body.pop_back());
      // header lead byte is never checked
      mark = ($urandom_range(0, 9) == 0) ? plain_byte() : ASCII_DOLLAR;
      put_count(mark, body.size());
      foreach (body[i]) stream.push_back(body[i]);
      if ($urandom_range(0, 99) < 85) begin
        put_crlf();
      end else begin
        stream.push_back(8'($urandom_range(0, 255)));
        stream.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic add_inline();
    int unsigned len;
    len = $urandom_range(0, 8);
    repeat (len) stream.push_back(plain_byte());
    if ($urandom_range(0, 4) == 0) stream.push_back(ASCII_CR);
    put_crlf();
  endtask

  task automatic add_noise();
    int unsigned len;
    len = $urandom_range(1, 6);
    repeat (len) stream.push_back(plain_byte() | ($urandom_range(0, 1) ? 8'h00 : 8'h0d));
    put_crlf();
  endtask

  // one byte through the input handshake
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b);
  endtask

  // hold off input until every owed result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic send_stream();
    while (stream.size() != 0) send_byte(stream.pop_front());
    drain();
  endtask

  task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_limit(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random stretch under a given pair of limits
  task automatic random_phase(input logic [31:0] len_lim, input logic [31:0] cnt_lim,
                              input bit calm, input int unsigned target);
    int unsigned counted;
    int unsigned pick;
    int unsigned s0;
    int unsigned pos;
    write_limit(REG_MAX_ELEMENT_LENGTH, len_lim);
    write_limit(REG_MAX_ELEMENT_COUNT, cnt_lim);
    idle_on = !calm;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      s0 = stream.size();
      if (pick < 65) begin
        add_array_command(1'b1);
      end else if (pick < 72) begin
        add_array_command(1'b0);
      end else if (pick < 82) begin
        // broken command: one byte overwritten
        add_array_command(1'b1);
        pos = $urandom_range(s0, stream.size() - 1);
        stream[pos] = 8'($urandom_range(0, 255));
      end else if (pick < 92) begin
        add_inline();
      end else begin
        add_noise();
      end
      counted += stream.size() - s0;
    end
    send_stream();
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: kinds, prefixes, empty and long commands, inline lines, errors
    // (octal 015 and 012 are carriage return and line feed)
    put_text("*1\015\012$4\015\012PING\015\012");
    put_text("*2\015\012$6\015\012select\015\012$1\015\012k\015\012");
    put_text("*2\015\012$3\015\012GET\015\012$3\015\012key\015\012");
    put_text("*1\015\012$4\015\012PiNG\015\012");
    put_text("*1\015\012$8\015\012PINGPONG\015\012");
    put_text("*1\015\012$3\015\012SEL\015\012");
    put_text("*0\015\012");
    put_text("*003\015\012$0\015\012\015\012$2\015\012ab\015\012$1\015\012c\015\012");
    put_text("*5\015\012$1\015\012a\015\012$1\015\012b\015\012$1\015\012c\015\012");
    put_text("$1\015\012d\015\012$1\015\012e\015\012");
    put_text("*1\015\012Z3\015\012abcXY");
    put_text("*1\015\012$2\015\012");
    stream.push_back(8'h00);
    stream.push_back(8'hff);
    put_crlf();
    put_text("PING\015\012\015\012ab\015\015\012x\015y\015\012");
    put_text("*\015\012*1xzz*1\015X");
    put_text("*4294967295\015\012$1x*42949672960*1\015\012$4294967296");
    send_stream();

    // lowest limits
    write_limit(REG_MAX_ELEMENT_LENGTH, 32'd0);
    write_limit(REG_MAX_ELEMENT_COUNT, 32'd0);
    put_text("*0\015\012*1\015\012*00\015\012");
    send_stream();
    write_limit(REG_MAX_ELEMENT_COUNT, 32'd1);
    put_text("*1\015\012$0\015\012\015\012*1\015\012$1\015\012");
    send_stream();
    write_limit(REG_MAX_ELEMENT_LENGTH, 32'd11);
    write_limit(REG_MAX_ELEMENT_COUNT, 32'd4);
    put_text("*2\015\012$1\015\012A\015\012$12\015\012");
    put_text("*2\015\012$1\015\012A\015\012$11\015\012hello world\015\012*5\015\012");
    send_stream();

    // random traffic, one stretch without any idling
    random_phase('1, '1, 1'b1, 120);
    random_phase(32'd12, 32'd3, 1'b0, 100);
    random_phase(32'd0, 32'd0, 1'b0, 40);
    random_phase($urandom_range(4, 40), $urandom_range(1, 6), 1'b0, 100);
    random_phase('1, $urandom, 1'b0, 100);
    random_phase(32'd6, 32'd2, 1'b0, 90);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d bytes: %0d commands (%0d ping, %0d select, %0d inline), %0d key bytes",
             board.checked, board.commands, board.pings, board.selects, board.inlines,
             board.key_bytes);
    $display("Errors seen: %0d bad digit or line end, %0d over limit; %0d mismatches",
             board.digit_errs, board.over_errs, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
